>>> hw/rtl/tga_dec_pkg.sv
// Shared types and constants of the TGA true-color image decoder.
package tga_dec_pkg;

    // Result kinds carried on the master-side tuser.
    localparam logic [1:0] KIND_RUN        = 2'd0;
    localparam logic [1:0] KIND_BAD_TYPE   = 2'd1;
    localparam logic [1:0] KIND_BAD_FORMAT = 2'd2;

    // Header byte positions.
    localparam logic [4:0] HDR_TYPE_POS     = 5'd2;
    localparam logic [4:0] HDR_ID_LAST_POS  = 5'd7;
    localparam logic [4:0] HDR_WIDTH_LO_POS = 5'd12;
    localparam logic [4:0] HDR_WIDTH_HI_POS = 5'd13;
    localparam logic [4:0] HDR_HEIGHT_LO_POS = 5'd14;
    localparam logic [4:0] HDR_HEIGHT_HI_POS = 5'd15;
    localparam logic [4:0] HDR_DEPTH_POS    = 5'd16;
    localparam logic [4:0] HDR_LAST_POS     = 5'd17;

    // Header codes.
    localparam logic [7:0] TYPE_RAW  = 8'd2;
    localparam logic [7:0] TYPE_RLE  = 8'd10;
    localparam logic [7:0] DEPTH_24  = 8'd24;
    localparam logic [7:0] DEPTH_32  = 8'd32;

    // RLE packet header: below MAX_PACKET is a raw group, else a repeat.
    localparam logic [7:0] MAX_PACKET   = 8'd128;
    localparam logic [7:0] PACKET_BIAS  = 8'd127;
    localparam logic [7:0] ALPHA_OPAQUE = 8'd255;

    // Master-side tdata layout, lowest bit first.
    localparam int START_LSB  = 0;
    localparam int COUNT_LSB  = 32;
    localparam int RED_LSB    = 40;
    localparam int GREEN_LSB  = 48;
    localparam int BLUE_LSB   = 56;
    localparam int ALPHA_LSB  = 64;
    localparam int WIDTH_LSB  = 72;
    localparam int HEIGHT_LSB = 88;
    localparam int M_DATA_W   = 104;

    typedef struct packed {
        logic [1:0]  kind;
        logic [31:0] start_index;
        logic [7:0]  repeat_count;
        logic [7:0]  red;
        logic [7:0]  green;
        logic [7:0]  blue;
        logic [7:0]  alpha;
        logic        image_done;
        logic [15:0] image_width;
        logic [15:0] image_height;
    } res_t;

endpackage

>>> hw/rtl/tga_dec_core.sv
// Decoder state and the per-byte step logic for header, packet and pixel bytes.
module tga_dec_core
(
    input  logic                 clk,
    input  logic                 rst_n,
    input  logic                 step,
    input  logic [7:0]           byte_value,
    input  logic                 first_byte,
    output logic                 res_valid,
    output tga_dec_pkg::res_t    res
);

    typedef enum logic [1:0] {PH_HEADER, PH_PKTHDR, PH_PIXEL, PH_IDLE} phase_t;

    phase_t      phase_reg, phase_next, eff_phase;
    logic [4:0]  hpos_reg, hpos_next, eff_hpos;
    logic        ok_reg, ok_next, eff_ok;
    logic        comp_reg, comp_next, eff_comp;
    logic [15:0] width_reg, width_next, eff_width;
    logic [15:0] height_reg, height_next, eff_height;
    logic        four_reg, four_next, eff_four;
    logic [7:0]  left_reg, left_next, eff_left;
    logic        isrep_reg, isrep_next, eff_isrep;
    logic [1:0]  cpos_reg, cpos_next, eff_cpos;
    logic [7:0]  blue_reg, blue_next;
    logic [7:0]  green_reg, green_next;
    logic [7:0]  red_reg, red_next;
    logic [31:0] done_reg, done_next, eff_done;
    logic [31:0] rem_reg, rem_next, eff_rem;

    logic [31:0] area;
    logic [1:0]  last_pos;
    logic        repeat_run;
    logic [7:0]  want;
    logic        rem_small;
    logic [7:0]  run_count;
    logic        run_done;

    // A first byte restarts the decoder, so the step sees the reset state.
    assign eff_phase  = first_byte ? PH_HEADER : phase_reg;
    assign eff_hpos   = first_byte ? 5'd0 : hpos_reg;
    assign eff_ok     = first_byte ? 1'b1 : ok_reg;
    assign eff_comp   = first_byte ? 1'b0 : comp_reg;
    assign eff_width  = first_byte ? 16'd0 : width_reg;
    assign eff_height = first_byte ? 16'd0 : height_reg;
    assign eff_four   = first_byte ? 1'b0 : four_reg;
    assign eff_left   = first_byte ? 8'd0 : left_reg;
    assign eff_isrep  = first_byte ? 1'b0 : isrep_reg;
    assign eff_cpos   = first_byte ? 2'd0 : cpos_reg;
    assign eff_done   = first_byte ? 32'd0 : done_reg;
    assign eff_rem    = first_byte ? 32'd0 : rem_reg;

    assign area       = {16'd0, eff_width} * {16'd0, eff_height};
    assign last_pos   = eff_four ? 2'd3 : 2'd2;
    assign repeat_run = eff_comp & eff_isrep;
    assign want       = repeat_run ? eff_left : 8'd1;

    // The run is clipped to the pixels left; only the low byte of the
    // remaining count matters once the upper bits are zero.
    assign rem_small  = (eff_rem[31:8] == 24'd0);
    assign run_count  = (!rem_small || (eff_rem[7:0] >= want)) ? want : eff_rem[7:0];
    assign run_done   = rem_small && (eff_rem[7:0] <= want);

    always_comb
    begin
        phase_next  = eff_phase;
        hpos_next   = eff_hpos;
        ok_next     = eff_ok;
        comp_next   = eff_comp;
        width_next  = eff_width;
        height_next = eff_height;
        four_next   = eff_four;
        left_next   = eff_left;
        isrep_next  = eff_isrep;
        cpos_next   = eff_cpos;
        blue_next   = blue_reg;
        green_next  = green_reg;
        red_next    = red_reg;
        done_next   = eff_done;
        rem_next    = eff_rem;
        res_valid   = 1'b0;
        res         = '0;

        case (eff_phase)
            PH_HEADER:
            begin
                hpos_next = eff_hpos + 5'd1;
                if (eff_hpos <= tga_dec_pkg::HDR_ID_LAST_POS)
                begin
                    if (eff_hpos == tga_dec_pkg::HDR_TYPE_POS)
                    begin
                        comp_next = (byte_value == tga_dec_pkg::TYPE_RLE);
                        if (byte_value != tga_dec_pkg::TYPE_RAW &&
                            byte_value != tga_dec_pkg::TYPE_RLE)
                        begin
                            ok_next = 1'b0;
                        end
                    end
                    else if (byte_value != 8'd0)
                    begin
                        ok_next = 1'b0;
                    end
                    if (eff_hpos == tga_dec_pkg::HDR_ID_LAST_POS && !ok_next)
                    begin
                        phase_next = PH_IDLE;
                        res_valid  = 1'b1;
                        res.kind   = tga_dec_pkg::KIND_BAD_TYPE;
                    end
                end
                else if (eff_hpos == tga_dec_pkg::HDR_WIDTH_LO_POS)
                begin
                    width_next = {eff_width[15:8], byte_value};
                end
                else if (eff_hpos == tga_dec_pkg::HDR_WIDTH_HI_POS)
                begin
                    width_next = {byte_value, eff_width[7:0]};
                end
                else if (eff_hpos == tga_dec_pkg::HDR_HEIGHT_LO_POS)
                begin
                    height_next = {eff_height[15:8], byte_value};
                end
                else if (eff_hpos == tga_dec_pkg::HDR_HEIGHT_HI_POS)
                begin
                    height_next = {byte_value, eff_height[7:0]};
                end
                else if (eff_hpos == tga_dec_pkg::HDR_DEPTH_POS)
                begin
                    ok_next   = (byte_value == tga_dec_pkg::DEPTH_24) ||
                                (byte_value == tga_dec_pkg::DEPTH_32);
                    four_next = (byte_value == tga_dec_pkg::DEPTH_32);
                end
                else if (eff_hpos >= tga_dec_pkg::HDR_LAST_POS)
                begin
                    if (!eff_ok || eff_width == 16'd0 || eff_height == 16'd0)
                    begin
                        phase_next       = PH_IDLE;
                        res_valid        = 1'b1;
                        res.kind         = tga_dec_pkg::KIND_BAD_FORMAT;
                        res.image_width  = eff_width;
                        res.image_height = eff_height;
                    end
                    else
                    begin
                        rem_next   = area;
                        done_next  = 32'd0;
                        cpos_next  = 2'd0;
                        phase_next = eff_comp ? PH_PKTHDR : PH_PIXEL;
                    end
                end
            end
            PH_PKTHDR:
            begin
                if (byte_value < tga_dec_pkg::MAX_PACKET)
                begin
                    isrep_next = 1'b0;
                    left_next  = byte_value + 8'd1;
                end
                else
                begin
                    isrep_next = 1'b1;
                    left_next  = byte_value - tga_dec_pkg::PACKET_BIAS;
                end
                cpos_next  = 2'd0;
                phase_next = PH_PIXEL;
            end
            PH_PIXEL:
            begin
                if (eff_cpos < last_pos)
                begin
                    case (eff_cpos)
                        2'd0:    blue_next  = byte_value;
                        2'd1:    green_next = byte_value;
                        default: red_next   = byte_value;
                    endcase
                    cpos_next = eff_cpos + 2'd1;
                end
                else
                begin
                    cpos_next = 2'd0;
                    if (eff_comp)
                    begin
                        if (repeat_run || eff_left <= 8'd1)
                        begin
                            left_next  = 8'd0;
                            phase_next = PH_PKTHDR;
                        end
                        else
                        begin
                            left_next = eff_left - 8'd1;
                        end
                    end
                    res_valid        = 1'b1;
                    res.kind         = tga_dec_pkg::KIND_RUN;
                    res.start_index  = eff_done;
                    res.repeat_count = run_count;
                    res.blue         = blue_reg;
                    res.green        = green_reg;
                    res.red          = eff_four ? red_reg : byte_value;
                    res.alpha        = eff_four ? byte_value :
                                       (repeat_run ? tga_dec_pkg::ALPHA_OPAQUE : 8'd0);
                    res.image_done   = run_done;
                    res.image_width  = eff_width;
                    res.image_height = eff_height;
                    done_next = eff_done + {24'd0, run_count};
                    rem_next  = eff_rem - {24'd0, run_count};
                    if (run_done)
                    begin
                        phase_next = PH_IDLE;
                    end
                end
            end
            default:
            begin
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            phase_reg  <= PH_HEADER;
            hpos_reg   <= 5'd0;
            ok_reg     <= 1'b1;
            comp_reg   <= 1'b0;
            width_reg  <= 16'd0;
            height_reg <= 16'd0;
            four_reg   <= 1'b0;
            left_reg   <= 8'd0;
            isrep_reg  <= 1'b0;
            cpos_reg   <= 2'd0;
            done_reg   <= 32'd0;
            rem_reg    <= 32'd0;
        end
        else if (step)
        begin
            phase_reg  <= phase_next;
            hpos_reg   <= hpos_next;
            ok_reg     <= ok_next;
            comp_reg   <= comp_next;
            width_reg  <= width_next;
            height_reg <= height_next;
            four_reg   <= four_next;
            left_reg   <= left_next;
            isrep_reg  <= isrep_next;
            cpos_reg   <= cpos_next;
            done_reg   <= done_next;
            rem_reg    <= rem_next;
        end
    end

    // Color bytes are payload and are always written before they are read.
    always_ff @(posedge clk)
    begin
        if (step)
        begin
            blue_reg  <= blue_next;
            green_reg <= green_next;
            red_reg   <= red_next;
        end
    end

endmodule

>>> hw/rtl/tga_dec_out.sv
// Output register of the decoder that drives the master-side stream.
module tga_dec_out
(
    input  logic                                  clk,
    input  logic                                  rst_n,
    input  logic                                  load,
    input  tga_dec_pkg::res_t                     res,
    output logic                                  free,
    output logic                                  m_tvalid,
    input  logic                                  m_tready,
    output logic [tga_dec_pkg::M_DATA_W-1:0]      m_tdata,
    output logic [1:0]                            m_tuser,
    output logic                                  m_tlast
);

    logic              valid_reg, valid_next;
    tga_dec_pkg::res_t res_reg;

    // The register can take a new item when empty or when its item leaves now.
    assign free = !valid_reg || m_tready;

    always_comb
    begin
        if (load)
        begin
            valid_next = 1'b1;
        end
        else if (m_tready)
        begin
            valid_next = 1'b0;
        end
        else
        begin
            valid_next = valid_reg;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            valid_reg <= 1'b0;
        end
        else
        begin
            valid_reg <= valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (load)
        begin
            res_reg <= res;
        end
    end

    assign m_tvalid = valid_reg;
    assign m_tuser  = res_reg.kind;
    assign m_tlast  = res_reg.image_done;
    assign m_tdata  = {res_reg.image_height, res_reg.image_width, res_reg.alpha,
                       res_reg.blue, res_reg.green, res_reg.red,
                       res_reg.repeat_count, res_reg.start_index};

endmodule

>>> hw/rtl/tga_rle_image_decoder.sv
// Top level of the TGA raw and RLE true-color decoder: input register, core, output register.
//
//  Channel   Dir  Signals                           Content
//  s_*       in   s_tvalid s_tready s_tdata s_tuser  one file byte, restart flag
//  m_*       out  m_tvalid m_tready m_tdata m_tuser  one pixel run or header error
//                 m_tlast
//
// One byte is taken per clock unless a stalled output holds a result; a byte passes from
// the input register through the step logic; any result it gives goes to the output register.
// The step logic between the two registers sets the rate: one byte per cycle.
// rst_n clears the decoder to wait for header byte 0; a restart flag on a byte
// does the same for that byte. A stalled output holds only bytes that give a result.
module tga_rle_image_decoder
(
    input  logic                                  clk,
    input  logic                                  rst_n,
    input  logic                                  s_tvalid,
    output logic                                  s_tready,
    input  logic [7:0]                            s_tdata,   // [7:0] byte_value
    input  logic [0:0]                            s_tuser,   // [0] first_byte
    output logic                                  m_tvalid,
    input  logic                                  m_tready,
    // [31:0] start_index, [39:32] repeat_count, [47:40] red, [55:48] green,
    // [63:56] blue, [71:64] alpha, [87:72] image_width, [103:88] image_height
    output logic [tga_dec_pkg::M_DATA_W-1:0]      m_tdata,
    output logic [1:0]                            m_tuser,   // [1:0] kind
    output logic                                  m_tlast    // image_done
);

    logic              in_valid_reg, in_valid_next;
    logic [7:0]        in_byte_reg;
    logic              in_first_reg;
    logic              step;
    logic              take;
    logic              res_valid;
    logic              out_free;
    tga_dec_pkg::res_t res;

    // A byte leaves the input register unless it gives a result that cannot be stored.
    assign step     = in_valid_reg && (!res_valid || out_free);
    assign s_tready = !in_valid_reg || step;
    assign take     = s_tvalid && s_tready;

    always_comb
    begin
        if (take)
        begin
            in_valid_next = 1'b1;
        end
        else if (step)
        begin
            in_valid_next = 1'b0;
        end
        else
        begin
            in_valid_next = in_valid_reg;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            in_valid_reg <= 1'b0;
        end
        else
        begin
            in_valid_reg <= in_valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (take)
        begin
            in_byte_reg  <= s_tdata;
            in_first_reg <= s_tuser[0];
        end
    end

    tga_dec_core u_core
    (
        .clk        (clk),
        .rst_n      (rst_n),
        .step       (step),
        .byte_value (in_byte_reg),
        .first_byte (in_first_reg),
        .res_valid  (res_valid),
        .res        (res)
    );

    tga_dec_out u_out
    (
        .clk      (clk),
        .rst_n    (rst_n),
        .load     (step && res_valid),
        .res      (res),
        .free     (out_free),
        .m_tvalid (m_tvalid),
        .m_tready (m_tready),
        .m_tdata  (m_tdata),
        .m_tuser  (m_tuser),
        .m_tlast  (m_tlast)
    );

`ifndef SYNTHESIS
    // A byte held in the input register is neither lost nor changed.
    assert property (@(posedge clk) disable iff (!rst_n)
        in_valid_reg && !step |=> in_valid_reg && $stable(in_byte_reg) &&
                                  $stable(in_first_reg))
    else $error("input byte lost while waiting");

    // Error results never claim to finish an image.
    assert property (@(posedge clk) disable iff (!rst_n)
        m_tvalid && m_tuser != tga_dec_pkg::KIND_RUN |-> !m_tlast)
    else $error("error result marked as image end");

    // Every pixel run covers between one and a full packet of pixels.
    assert property (@(posedge clk) disable iff (!rst_n)
        m_tvalid && m_tuser == tga_dec_pkg::KIND_RUN |->
            m_tdata[tga_dec_pkg::COUNT_LSB +: 8] != 8'd0 &&
            m_tdata[tga_dec_pkg::COUNT_LSB +: 8] <= tga_dec_pkg::MAX_PACKET)
    else $error("pixel run count out of range");

    // A new result is loaded only when the previous one has left or is leaving.
    assert property (@(posedge clk) disable iff (!rst_n)
        m_tvalid && !m_tready |-> !(step && res_valid))
    else $error("output register overwritten");
`endif

endmodule

>>> bench/tb_top.sv
// Testbench of the TGA raw and RLE decoder: directed and random files and noise checked against a predictor.
`timescale 1ns / 100ps

module tb_top;
    import tga_dec_pkg::*;

    typedef enum logic [1:0] {DEC_HEADER, DEC_PACKET, DEC_PIXEL, DEC_IDLE} dec_phase_t;

    logic                clk = 1'b0;
    logic                rst_n = 1'b0;
    logic                s_tvalid = 1'b0;
    logic                s_tready;
    logic [7:0]          s_tdata = 8'd0;
    logic [0:0]          s_tuser = 1'b0;
    logic                m_tvalid;
    logic                m_tready = 1'b0;
    logic [M_DATA_W-1:0] m_tdata;
    logic [1:0]          m_tuser;
    logic                m_tlast;

    int send_idle_pct = 0;
    int recv_stall_pct = 0;
    int errors = 0;
    int decoded_bytes = 0;

    // Decoder state as the predictor sees it.
    dec_phase_t  dec_phase;
    logic [4:0]  hdr_pos;
    logic        hdr_ok;
    logic        rle_mode;
    logic [15:0] img_w;
    logic [15:0] img_h;
    logic        has_alpha;
    logic [7:0]  pkt_left;
    logic        pkt_repeat;
    logic [1:0]  col_pos;
    logic [23:0] col_acc;
    logic [31:0] px_done;
    logic [31:0] px_total;

    res_t pending_runs[$];

    tga_rle_image_decoder i_dut
    (
        .clk      (clk),
        .rst_n    (rst_n),
        .s_tvalid (s_tvalid),
        .s_tready (s_tready),
        .s_tdata  (s_tdata),
        .s_tuser  (s_tuser),
        .m_tvalid (m_tvalid),
        .m_tready (m_tready),
        .m_tdata  (m_tdata),
        .m_tuser  (m_tuser),
        .m_tlast  (m_tlast)
    );

    always
    begin
        #2 clk = 1'b1;
        #2 clk = 1'b0;
    end

    initial
    begin
        #2_000_000;
        $display("TEST FAILED");
        $finish;
    end

    always @(posedge clk)
    begin
        m_tready <= ($urandom_range(99) >= recv_stall_pct);
    end

    function automatic void clear_decoder();
        dec_phase  = DEC_HEADER;
        hdr_pos    = 5'd0;
        hdr_ok     = 1'b1;
        rle_mode   = 1'b0;
        img_w      = 16'd0;
        img_h      = 16'd0;
        has_alpha  = 1'b0;
        pkt_left   = 8'd0;
        pkt_repeat = 1'b0;
        col_pos    = 2'd0;
        col_acc    = 24'd0;
        px_done    = 32'd0;
        px_total   = 32'd0;
    endfunction

    // A run is clipped to the pixels the image still lacks.
    function automatic void emit_run(input logic [31:0] want, input logic [7:0] red,
                                     input logic [7:0] green, input logic [7:0] blue,
                                     input logic [7:0] alpha);
        res_t        r;
        logic [31:0] remaining;
        logic [31:0] cnt;
        remaining = px_total - px_done;
        cnt = (want < remaining) ? want : remaining;
        r = '0;
        r.kind = KIND_RUN;
        r.start_index = px_done;
        r.repeat_count = cnt[7:0];
        r.red = red;
        r.green = green;
        r.blue = blue;
        r.alpha = alpha;
        px_done = px_done + cnt;
        r.image_done = (px_done >= px_total);
        r.image_width = img_w;
        r.image_height = img_h;
        if (r.image_done)
            dec_phase = DEC_IDLE;
        pending_runs.push_back(r);
    endfunction

    // Returns 1 when the byte was taken into the decoding rather than ignored.
    function automatic bit decode_byte(input logic [7:0] b, input logic first);
        logic [4:0]  pos;
        logic [1:0]  last_pos;
        logic        is_rep;
        logic [7:0]  red;
        logic [7:0]  alpha;
        logic [31:0] want;
        res_t        r;
        if (first)
            clear_decoder();
        if (dec_phase == DEC_IDLE)
            return 1'b0;
        case (dec_phase)
            DEC_HEADER:
            begin
                pos = hdr_pos;
                hdr_pos = hdr_pos + 5'd1;
                if (pos <= HDR_ID_LAST_POS)
                begin
                    if (pos == HDR_TYPE_POS)
                    begin
                        rle_mode = (b == TYPE_RLE);
                        if (b != TYPE_RAW && b != TYPE_RLE)
                            hdr_ok = 1'b0;
                    end
                    else if (b != 8'd0)
                        hdr_ok = 1'b0;
                    if (pos == HDR_ID_LAST_POS && !hdr_ok)
                    begin
                        dec_phase = DEC_IDLE;
                        r = '0;
                        r.kind = KIND_BAD_TYPE;
                        pending_runs.push_back(r);
                    end
                end
                else if (pos == HDR_WIDTH_LO_POS)
                    img_w[7:0] = b;
                else if (pos == HDR_WIDTH_HI_POS)
                    img_w[15:8] = b;
                else if (pos == HDR_HEIGHT_LO_POS)
                    img_h[7:0] = b;
                else if (pos == HDR_HEIGHT_HI_POS)
                    img_h[15:8] = b;
                else if (pos == HDR_DEPTH_POS)
                begin
                    hdr_ok = (b == DEPTH_24 || b == DEPTH_32);
                    has_alpha = (b == DEPTH_32);
                end
                else if (pos >= HDR_LAST_POS)
                begin
                    if (!hdr_ok || img_w == 16'd0 || img_h == 16'd0)
                    begin
                        dec_phase = DEC_IDLE;
                        r = '0;
                        r.kind = KIND_BAD_FORMAT;
                        r.image_width = img_w;
                        r.image_height = img_h;
                        pending_runs.push_back(r);
                    end
                    else
                    begin
                        px_total = 32'(img_w) * 32'(img_h);
                        px_done = 32'd0;
                        col_pos = 2'd0;
                        col_acc = 24'd0;
                        dec_phase = rle_mode ? DEC_PACKET : DEC_PIXEL;
                    end
                end
            end
            DEC_PACKET:
            begin
                if (b < MAX_PACKET)
                begin
                    pkt_repeat = 1'b0;
                    pkt_left = b + 8'd1;
                end
                else
                begin
                    pkt_repeat = 1'b1;
                    pkt_left = b - PACKET_BIAS;
                end
                col_pos = 2'd0;
                col_acc = 24'd0;
                dec_phase = DEC_PIXEL;
            end
            DEC_PIXEL:
            begin
                last_pos = has_alpha ? 2'd3 : 2'd2;
                if (col_pos < last_pos)
                begin
                    col_acc[col_pos * 8 +: 8] = b;
                    col_pos = col_pos + 2'd1;
                end
                else
                begin
                    // File order is blue, green, red, then alpha for 32-bit pixels.
                    is_rep = rle_mode && pkt_repeat;
                    red = has_alpha ? col_acc[23:16] : b;
                    alpha = has_alpha ? b : (is_rep ? ALPHA_OPAQUE : 8'd0);
                    want = is_rep ? 32'(pkt_left) : 32'd1;
                    col_pos = 2'd0;
                    if (rle_mode)
                    begin
                        if (is_rep || pkt_left <= 8'd1)
                        begin
                            pkt_left = 8'd0;
                            dec_phase = DEC_PACKET;
                        end
                        else
                            pkt_left = pkt_left - 8'd1;
                    end
                    emit_run(want, red, col_acc[15:8], col_acc[7:0], alpha);
                    col_acc = 24'd0;
                end
            end
            default:
            begin
            end
        endcase
        return 1'b1;
    endfunction

    task automatic check_field(input string name, input logic [31:0] expv,
                               input logic [31:0] gotv);
        if (gotv !== expv)
        begin
            $display("%0t: %s mismatch: expected %0h, actual %0h", $time, name, expv, gotv);
            errors++;
        end
    endtask

    // Outputs are sampled on the falling clock edge, before the rising edge that moves the item.
    always @(negedge clk)
    begin : result_check
        res_t got;
        res_t exp_run;
        if (rst_n && m_tvalid && m_tready)
        begin
            got.kind = m_tuser;
            got.start_index = m_tdata[START_LSB +: 32];
            got.repeat_count = m_tdata[COUNT_LSB +: 8];
            got.red = m_tdata[RED_LSB +: 8];
            got.green = m_tdata[GREEN_LSB +: 8];
            got.blue = m_tdata[BLUE_LSB +: 8];
            got.alpha = m_tdata[ALPHA_LSB +: 8];
            got.image_done = m_tlast;
            got.image_width = m_tdata[WIDTH_LSB +: 16];
            got.image_height = m_tdata[HEIGHT_LSB +: 16];
            if (pending_runs.size() == 0)
            begin
                $display("%0t: result with none expected: kind %0d start %0d count %0d",
                         $time, got.kind, got.start_index, got.repeat_count);
                errors++;
            end
            else
            begin
                exp_run = pending_runs.pop_front();
                check_field("kind", 32'(exp_run.kind), 32'(got.kind));
                check_field("start_index", exp_run.start_index, got.start_index);
                check_field("repeat_count", 32'(exp_run.repeat_count),
                            32'(got.repeat_count));
                check_field("red", 32'(exp_run.red), 32'(got.red));
                check_field("green", 32'(exp_run.green), 32'(got.green));
                check_field("blue", 32'(exp_run.blue), 32'(got.blue));
                check_field("alpha", 32'(exp_run.alpha), 32'(got.alpha));
                check_field("image_done", 32'(exp_run.image_done), 32'(got.image_done));
                check_field("image_width", 32'(exp_run.image_width),
                            32'(got.image_width));
                check_field("image_height", 32'(exp_run.image_height),
                            32'(got.image_height));
            end
        end
    end

    task automatic send_byte(input logic [7:0] b, input logic first);
        bit taken;
        if (send_idle_pct != 0 && $urandom_range(99) < send_idle_pct)
        begin
            s_tvalid <= 1'b0;
            do
                @(posedge clk);
            while ($urandom_range(99) < send_idle_pct);
        end
        s_tvalid <= 1'b1;
        s_tdata <= b;
        s_tuser <= first;
        do
        begin
            @(negedge clk);
            taken = s_tready;
            @(posedge clk);
        end
        while (!taken);
        if (decode_byte(b, first))
            decoded_bytes++;
    endtask

    // A negative fill gives random channel bytes.
    task automatic send_color(input bit four, input int fill);
        int i;
        for (i = 0; i < (four ? 4 : 3); i++)
            send_byte((fill < 0) ? 8'($urandom_range(255)) : 8'(fill), 1'b0);
    endtask

    // Sends the first n_bytes of a header; bad_pos, if not negative, gets a nonzero byte.
    task automatic send_header(input logic [7:0] ftype, input logic [15:0] w,
                               input logic [15:0] h, input logic [7:0] depth,
                               input int bad_pos, input int n_bytes, input logic restart);
        logic [7:0] hdr [18];
        int         i;
        for (i = 0; i < 18; i++)
            hdr[i] = 8'($urandom_range(255));
        for (i = 0; i < 8; i++)
            hdr[i] = 8'd0;
        hdr[HDR_TYPE_POS] = ftype;
        hdr[HDR_WIDTH_LO_POS] = w[7:0];
        hdr[HDR_WIDTH_HI_POS] = w[15:8];
        hdr[HDR_HEIGHT_LO_POS] = h[7:0];
        hdr[HDR_HEIGHT_HI_POS] = h[15:8];
        hdr[HDR_DEPTH_POS] = depth;
        if (bad_pos >= 0)
            hdr[bad_pos] = 8'($urandom_range(1, 255));
        for (i = 0; i < n_bytes; i++)
            send_byte(hdr[i], (i == 0) ? restart : 1'b0);
    endtask

    task automatic drain_runs();
        s_tvalid <= 1'b0;
        do
            @(posedge clk);
        while (pending_runs.size() != 0);
    endtask

    task automatic test_bad_type();
        // The first file follows reset without a restart flag.
        send_header(8'd3, 16'd1, 16'd1, DEPTH_24, -1, 18, 1'b0);
        send_header(TYPE_RLE, 16'd1, 16'd1, DEPTH_24, int'(HDR_ID_LAST_POS), 8, 1'b1);
        send_header(TYPE_RAW, 16'd1, 16'd1, DEPTH_32, 0, 8, 1'b1);
    endtask

    task automatic test_bad_format();
        send_header(TYPE_RAW, 16'd0, 16'd5, DEPTH_24, -1, 18, 1'b1);
        send_header(TYPE_RLE, 16'hFFFF, 16'hFFFF, 8'd16, -1, 18, 1'b1);
        send_header(TYPE_RAW, 16'd7, 16'd0, DEPTH_32, -1, 18, 1'b1);
    endtask

    task automatic test_raw_image();
        send_header(TYPE_RAW, 16'd2, 16'd1, DEPTH_32, -1, 18, 1'b1);
        send_color(1'b1, 255);
        send_color(1'b1, 0);
        send_byte(8'hA5, 1'b0);
        send_header(TYPE_RAW, 16'd1, 16'd1, DEPTH_24, -1, 18, 1'b1);
        send_color(1'b0, -1);
    endtask

    task automatic test_rle_image();
        // A repeat of two, a raw pair, then a repeat of 128 clipped to the last two pixels.
        send_header(TYPE_RLE, 16'd3, 16'd2, DEPTH_24, -1, 18, 1'b1);
        send_byte(8'h81, 1'b0);
        send_color(1'b0, -1);
        send_byte(8'h01, 1'b0);
        send_color(1'b0, -1);
        send_color(1'b0, -1);
        send_byte(8'hFF, 1'b0);
        send_color(1'b0, -1);
        send_byte(8'h5A, 1'b0);
        // A raw packet of 128 in a one-pixel image drops all but its first pixel.
        send_header(TYPE_RLE, 16'd1, 16'd1, DEPTH_32, -1, 18, 1'b1);
        send_byte(8'h7F, 1'b0);
        send_color(1'b1, -1);
        send_color(1'b1, -1);
        send_header(TYPE_RLE, 16'd16, 16'd8, DEPTH_32, -1, 18, 1'b1);
        send_byte(8'hFF, 1'b0);
        send_color(1'b1, -1);
        send_header(TYPE_RLE, 16'd2, 16'd1, DEPTH_24, -1, 18, 1'b1);
        send_byte(8'h00, 1'b0);
        send_color(1'b0, -1);
        send_byte(8'h80, 1'b0);
        send_color(1'b0, -1);
    endtask

    task automatic send_random_file();
        int         sel;
        int         bad_pos;
        int         n_bytes;
        int         left;
        int         run_len;
        int         k;
        bit         large_img;
        bit         four;
        logic [7:0] ftype;
        logic [7:0] depth;
        logic [7:0] pkt_hdr;
        logic [15:0] w;
        logic [15:0] h;
        sel = $urandom_range(99);
        ftype = $urandom_range(1) ? TYPE_RLE : TYPE_RAW;
        depth = $urandom_range(1) ? DEPTH_32 : DEPTH_24;
        w = 16'($urandom_range(1, ($urandom_range(3) == 0) ? 8 : 4));
        h = 16'($urandom_range(1, ($urandom_range(3) == 0) ? 5 : 3));
        bad_pos = -1;
        n_bytes = 18;
        large_img = 1'b0;
        if (sel < 4)
            ftype = 8'($urandom_range(255));
        else if (sel < 7)
        begin
            bad_pos = $urandom_range(6);
            if (bad_pos >= HDR_TYPE_POS)
                bad_pos++;
        end
        else if (sel < 10)
            depth = 8'($urandom_range(255));
        else if (sel < 13)
        begin
            case ($urandom_range(2))
                0: w = 16'd0;
                1: h = 16'd0;
                default:
                begin
                    w = 16'd0;
                    h = 16'd0;
                end
            endcase
        end
        else if (sel < 16)
            n_bytes = $urandom_range(1, 17);
        else if (sel < 22)
        begin
            // Too big to finish: up to 200 pixels, then the next file cuts it off.
            large_img = 1'b1;
            w = 16'($urandom_range(256, 65535));
            h = 16'($urandom_range(256, 65535));
            if ($urandom_range(3) == 0)
            begin
                w = 16'hFFFF;
                h = 16'hFFFF;
            end
        end
        four = (depth == DEPTH_32);
        send_header(ftype, w, h, depth, bad_pos, n_bytes, 1'b1);
        if (n_bytes < 18)
            return;
        if (dec_phase != DEC_IDLE)
        begin
            left = large_img ? $urandom_range(1, 200) : int'(w) * int'(h);
            if (ftype == TYPE_RAW)
            begin
                for (k = 0; k < left; k++)
                    send_color(four, -1);
            end
            else
            begin
                while (left > 0)
                begin
                    case ($urandom_range(3))
                        0: pkt_hdr = 8'($urandom_range(0, 127));
                        1: pkt_hdr = 8'($urandom_range(128, 255));
                        2: pkt_hdr = 8'($urandom_range(0, 3));
                        default: pkt_hdr = 8'($urandom_range(128, 131));
                    endcase
                    send_byte(pkt_hdr, 1'b0);
                    if (pkt_hdr < MAX_PACKET)
                    begin
                        for (k = 0; k <= int'(pkt_hdr) && left > 0; k++)
                        begin
                            send_color(four, -1);
                            left--;
                        end
                    end
                    else
                    begin
                        send_color(four, -1);
                        run_len = int'(pkt_hdr) - int'(PACKET_BIAS);
                        left = (run_len >= left) ? 0 : left - run_len;
                    end
                end
            end
        end
        // Bytes past the end of the image or after an error are ignored.
        if ($urandom_range(99) < 30)
            for (k = $urandom_range(1, 3); k > 0; k--)
                send_byte(8'($urandom_range(255)), 1'b0);
    endtask

    task automatic test_random_files(input int send_pct, input int recv_pct, input int n_items);
        int goal;
        int k;
        send_idle_pct = send_pct;
        recv_stall_pct = recv_pct;
        goal = decoded_bytes + n_items;
        while (decoded_bytes < goal)
        begin
            if ($urandom_range(99) < 85)
                send_random_file();
            else
                for (k = $urandom_range(4, 12); k > 0; k--)
                    send_byte(8'($urandom_range(255)), $urandom_range(99) < 15);
        end
        drain_runs();
    endtask

    initial
    begin
        clear_decoder();
        send_idle_pct = 17;
        recv_stall_pct = 46;
        repeat (4) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);
        test_bad_type();
        test_bad_format();
        test_raw_image();
        test_rle_image();
        drain_runs();
        test_random_files(17, 46, 200);
        test_random_files(46, 17, 200);
        test_random_files(0, 0, 200);
        drain_runs();
        repeat (20) @(posedge clk);
        if (errors == 0)
            $display("TEST PASSED");
        else
            $display("TEST FAILED");
        $finish;
    end

endmodule

>>> sim.f
hw/rtl/tga_dec_pkg.sv
hw/rtl/tga_dec_core.sv
hw/rtl/tga_dec_out.sv
hw/rtl/tga_rle_image_decoder.sv
bench/tb_top.sv
